/* hw/rtl/hvd_pkg.sv */
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared types and constants of the video-RAM DMA controller.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CMD_DEPTH_DEFAULT = 2;
    localparam int RES_DEPTH_DEFAULT = 2;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_HBLANK = 2'd2;

    localparam logic [2:0] REG_SRC_HI = 3'd1;
    localparam logic [2:0] REG_SRC_LO = 3'd2;
    localparam logic [2:0] REG_DST_HI = 3'd3;
    localparam logic [2:0] REG_DST_LO = 3'd4;
    localparam logic [2:0] REG_CTRL   = 3'd5;

    localparam int NUM_REGS = 5;

    localparam logic [15:0] SRC_RESET      = 16'hFFF0;
    localparam logic [15:0] DST_RESET      = 16'h9FF0;
    localparam logic [15:0] ALIGN_MASK     = 16'hFFF0;
    localparam logic [15:0] VRAM_OFS_MASK  = 16'h1FF0;
    localparam logic [15:0] VRAM_BASE      = 16'h8000;
    localparam logic [15:0] VRAM_END       = 16'hA000;
    localparam logic [15:0] BLOCK_BYTES    = 16'h0010;
    localparam logic [3:0]  WRAM_BANK_NIB  = 4'hD;
    localparam logic [7:0]  BYTE_RESET     = 8'hFF;
    localparam logic [11:0] HBLANK_LENGTH  = 12'h010;
    localparam logic [13:0] HBLANK_STALL_DS = 14'd68;
    localparam logic [13:0] HBLANK_STALL_SS = 14'd36;
    localparam logic [13:0] GENERAL_BASE_DS = 14'd8;
    localparam logic [13:0] GENERAL_BASE_SS = 14'd4;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_WR_SRC_HI,
        CMD_WR_SRC_LO,
        CMD_WR_DST_HI,
        CMD_WR_DST_LO,
        CMD_WR_CTRL,
        CMD_READ,
        CMD_HBLANK
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic       in_hblank;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        hblank_active;
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [15:0] copy_dest;
        logic [11:0] copy_length;
        logic        banked_wram_source;
        logic [13:0] stall_cycles;
    } result_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       in_hblank;
        logic [2:0] sel;
    } cmd_t;

endpackage

/* hw/rtl/hvd_fifo.sv */
// ----------------------------------------------------------------------------
// hvd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hvd_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/hvd_front.sv */
// ----------------------------------------------------------------------------
// hvd_front
// Accepts bus items, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module hvd_front #(
    parameter int CMD_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  hvd_pkg::item_t item,
    input  logic          cmd_pop,
    output logic          cmd_empty,
    output hvd_pkg::cmd_t cmd
);
    import hvd_pkg::*;

    cmd_t dec;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        dec.kind      = CMD_NOP;
        dec.data      = item.write_data;
        dec.in_hblank = item.in_hblank;
        dec.sel       = item.reg_index - 3'd1;
        unique case (item.opcode)
            OP_WRITE:
            begin
                unique case (item.reg_index)
                    REG_SRC_HI:
                    begin
                        dec.kind = CMD_WR_SRC_HI;
                        if (item.write_data[7:5] == 3'b100)
                        begin
                            dec.data = 8'h00;
                        end
                    end
                    REG_SRC_LO:
                    begin
                        dec.kind = CMD_WR_SRC_LO;
                        dec.data = {item.write_data[7:4], 4'h0};
                    end
                    REG_DST_HI:
                    begin
                        dec.kind = CMD_WR_DST_HI;
                        dec.data = {3'b000, item.write_data[4:0]};
                    end
                    REG_DST_LO:
                    begin
                        dec.kind = CMD_WR_DST_LO;
                        dec.data = {item.write_data[7:4], 4'h0};
                    end
                    REG_CTRL:
                    begin
                        dec.kind = CMD_WR_CTRL;
                    end
                    default:
                    begin
                        dec.kind = CMD_NOP;
                    end
                endcase
            end
            OP_READ:
            begin
                if (item.reg_index >= REG_SRC_HI && item.reg_index <= REG_CTRL)
                begin
                    dec.kind = CMD_READ;
                end
            end
            OP_HBLANK:
            begin
                dec.kind = CMD_HBLANK;
            end
            default:
            begin
                dec.kind = CMD_NOP;
            end
        endcase
    end

    hvd_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (dec),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_bits)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

/* hw/rtl/hvd_back.sv */
// ----------------------------------------------------------------------------
// hvd_back
// Executes queued commands against the DMA state and queues the results.
// ----------------------------------------------------------------------------
module hvd_back #(
    parameter int RES_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_wdata,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  hvd_pkg::cmd_t   cmd,
    input  logic            pop,
    output logic            empty,
    output hvd_pkg::result_t result
);
    import hvd_pkg::*;

    logic        ds_reg;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [7:0]  bytes_reg [NUM_REGS];
    logic [7:0]  bytes_next [NUM_REGS];
    logic        en_reg, en_next;
    logic [11:0] bp_reg, bp_next;

    logic        res_full;
    logic        go;
    result_t     res;
    logic [$bits(result_t)-1:0] res_bits;

    logic [7:0]  blocks;
    logic [11:0] bp_new;
    logic        do_block;
    logic [7:0]  blk_reg5;
    logic [7:0]  blk_reg5_dec;
    logic [11:0] blk_bp;
    logic [15:0] cur_src;
    logic [15:0] cur_dst;
    logic [15:0] src_inc;
    logic [15:0] dst_inc;
    logic [15:0] src_adv;
    logic [15:0] dst_adv;

    assign go      = !cmd_empty && !res_full;
    assign cmd_pop = go;

    assign blocks  = {1'b0, cmd.data[6:0]} + 8'd1;
    assign bp_new  = {blocks, 4'h0};
    assign cur_src = src_reg & ALIGN_MASK;
    assign cur_dst = (dst_reg & VRAM_OFS_MASK) | VRAM_BASE;
    assign src_inc = src_reg + BLOCK_BYTES;
    assign dst_inc = dst_reg + BLOCK_BYTES;
    assign src_adv = (src_inc == VRAM_BASE) ? VRAM_END : src_inc;
    assign dst_adv = (dst_inc == VRAM_END) ? VRAM_BASE : dst_inc;
    assign blk_reg5_dec = blk_reg5 - 8'd1;

    always_comb
    begin
        src_next = src_reg;
        dst_next = dst_reg;
        en_next  = en_reg;
        bp_next  = bp_reg;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            bytes_next[i] = bytes_reg[i];
        end
        res      = '0;
        do_block = 1'b0;
        blk_reg5 = bytes_reg[4];
        blk_bp   = bp_reg;

        unique case (cmd.kind)
            CMD_WR_SRC_HI:
            begin
                src_next      = {cmd.data, src_reg[7:4], 4'h0};
                bytes_next[0] = cmd.data;
            end
            CMD_WR_SRC_LO:
            begin
                src_next      = {src_reg[15:8], cmd.data};
                bytes_next[1] = cmd.data;
            end
            CMD_WR_DST_HI:
            begin
                dst_next      = {3'b100, cmd.data[4:0], dst_reg[7:4], 4'h0};
                bytes_next[2] = cmd.data;
            end
            CMD_WR_DST_LO:
            begin
                dst_next      = {3'b100, dst_reg[12:8], cmd.data};
                bytes_next[3] = cmd.data;
            end
            CMD_WR_CTRL:
            begin
                bp_next = bp_new;
                if (en_reg)
                begin
                    if (cmd.data[7])
                    begin
                        bytes_next[4] = {1'b0, cmd.data[6:0]};
                    end
                    else
                    begin
                        bytes_next[4] = BYTE_RESET;
                        en_next       = 1'b0;
                    end
                end
                else if (cmd.data[7])
                begin
                    en_next       = 1'b1;
                    bytes_next[4] = {1'b0, cmd.data[6:0]};
                    do_block      = cmd.in_hblank;
                    blk_reg5      = {1'b0, cmd.data[6:0]};
                    blk_bp        = bp_new;
                end
                else
                begin
                    res.copy_valid  = 1'b1;
                    res.copy_source = cur_src;
                    res.copy_dest   = cur_dst;
                    res.copy_length = bp_new;
                    res.banked_wram_source = (cur_src[15:12] == WRAM_BANK_NIB);
                    res.stall_cycles = ds_reg ? ({blocks, 6'b0} + GENERAL_BASE_DS)
                                              : ({1'b0, blocks, 5'b0} + GENERAL_BASE_SS);
                    src_next = src_reg + {4'h0, bp_new};
                    dst_next = dst_reg + {4'h0, bp_new};
                    for (int i = 0; i < NUM_REGS; i++)
                    begin
                        bytes_next[i] = BYTE_RESET;
                    end
                end
            end
            CMD_READ:
            begin
                res.read_data = bytes_reg[cmd.sel];
            end
            CMD_HBLANK:
            begin
                do_block = en_reg;
            end
            CMD_NOP:
            begin
                res = '0;
            end
            default:
            begin
                res = '0;
            end
        endcase

        if (do_block)
        begin
            res.copy_valid  = 1'b1;
            res.copy_source = cur_src;
            res.copy_dest   = cur_dst;
            res.copy_length = HBLANK_LENGTH;
            res.banked_wram_source = (cur_src[15:12] == WRAM_BANK_NIB);
            res.stall_cycles = ds_reg ? HBLANK_STALL_DS : HBLANK_STALL_SS;
            src_next      = src_adv;
            dst_next      = dst_adv;
            bytes_next[0] = src_adv[15:8];
            bytes_next[1] = src_adv[7:0];
            bytes_next[2] = dst_adv[15:8];
            bytes_next[3] = dst_adv[7:0];
            bp_next       = blk_bp - HBLANK_LENGTH;
            bytes_next[4] = blk_reg5_dec;
            if (blk_reg5_dec == BYTE_RESET)
            begin
                en_next = 1'b0;
            end
        end

        res.hblank_active = en_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg  <= 1'b0;
            src_reg <= SRC_RESET;
            dst_reg <= DST_RESET;
            en_reg  <= 1'b0;
            bp_reg  <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                bytes_reg[i] <= BYTE_RESET;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                ds_reg <= cfg_wdata;
            end
            if (go)
            begin
                src_reg <= src_next;
                dst_reg <= dst_next;
                en_reg  <= en_next;
                bp_reg  <= bp_next;
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    bytes_reg[i] <= bytes_next[i];
                end
            end
        end
    end

    hvd_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (go),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (res_bits)
    );

    assign result = result_t'(res_bits);

endmodule

/* hw/rtl/hblank_vram_dma_controller.sv */
// ----------------------------------------------------------------------------
// hblank_vram_dma_controller
// Video-RAM DMA controller: decodes register and HBlank events, returns register
// read data and issues copy commands with their CPU stall cost.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        item   (hvd_pkg::item_t)
//  result    empty / pop        result (hvd_pkg::result_t)
//  config    cfg_we             cfg_wdata (double speed)
//
// One item is accepted per cycle while full is low; it is registered in the
// command queue, then executed; its result waits in the result queue for pop.
// The executor handles one command per cycle unless the result queue is full
// and holds all DMA state. Reset sets the DMA registers and queue pointers
// to their power-on values at once; the queue storage itself is not reset.
// A full result queue stalls the executor; the command queue then fills and
// raises full.
// ----------------------------------------------------------------------------
module hblank_vram_dma_controller #(
    parameter int CMD_DEPTH = hvd_pkg::CMD_DEPTH_DEFAULT,
    parameter int RES_DEPTH = hvd_pkg::RES_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  hvd_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output hvd_pkg::result_t result,
    input  logic             cfg_we,
    input  logic             cfg_wdata
);
    import hvd_pkg::*;

    logic cmd_empty;
    logic cmd_pop;
    cmd_t cmd;

    hvd_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    hvd_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
